>>> hw/rtl/tkrs_pkg.sv
// ----------------------------------------------------------------------------
// tkrs_pkg: shared types and constants for the three-key record sorter
// Record and result layouts, queue entry type, controller states and key order.
// ----------------------------------------------------------------------------
package tkrs_pkg;

  localparam int unsigned MaxRecordsDefault = 64;
  localparam int unsigned KeyW              = 32;
  localparam int unsigned QueueDepth        = 2;

  typedef struct packed {
    logic signed [KeyW-1:0] key_first;
    logic signed [KeyW-1:0] key_second;
    logic signed [KeyW-1:0] key_third;
    logic                   batch_end;
  } in_rec_t;

  typedef struct packed {
    logic signed [KeyW-1:0] out_first;
    logic signed [KeyW-1:0] out_second;
    logic signed [KeyW-1:0] out_third;
    logic                   out_last;
    logic                   overflow;
  } out_rec_t;

  typedef struct packed {
    logic [KeyW-1:0] k0;
    logic [KeyW-1:0] k1;
    logic [KeyW-1:0] k2;
  } rec_t;

  // one classified item handed from the front to the back
  typedef struct packed {
    rec_t rec;
    logic keep;       // room left: store it
    logic close;      // batch ends with this item
    logic dropped;    // batch has dropped a record so far
  } q_ent_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SORT,
    ST_EMIT
  } bk_state_t;

  // strict descending order: x comes before y
  function automatic logic goes_before(input rec_t x, input rec_t y);
    logic [KeyW-1:0] a0, a1, a2, b0, b1, b2;
    begin
      a0 = x.k0 ^ {1'b1, {(KeyW-1){1'b0}}};
      a1 = x.k1 ^ {1'b1, {(KeyW-1){1'b0}}};
      a2 = x.k2 ^ {1'b1, {(KeyW-1){1'b0}}};
      b0 = y.k0 ^ {1'b1, {(KeyW-1){1'b0}}};
      b1 = y.k1 ^ {1'b1, {(KeyW-1){1'b0}}};
      b2 = y.k2 ^ {1'b1, {(KeyW-1){1'b0}}};
      if (a0 != b0) goes_before = a0 > b0;
      else if (a1 != b1) goes_before = a1 > b1;
      else goes_before = a2 > b2;
    end
  endfunction

endpackage

>>> hw/rtl/tkrs_front.sv
// ----------------------------------------------------------------------------
// tkrs_front: input classifier
// Counts records of the current batch, marks each as kept or dropped and
// tracks the batch overflow flag; pushes classified items into the queue.
// ----------------------------------------------------------------------------
module tkrs_front #(
  parameter int unsigned MAX_RECORDS = tkrs_pkg::MaxRecordsDefault
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  tkrs_pkg::in_rec_t in_data,
  output logic              push,
  output tkrs_pkg::q_ent_t  push_ent,
  input  logic              q_full
);

  localparam int unsigned CntW = $clog2(MAX_RECORDS + 1);

  logic [CntW-1:0] count_r, count_nxt;
  logic            drop_r, drop_nxt;
  logic            keep;

  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;
  assign keep     = count_r != CntW'(MAX_RECORDS);

  // classify the incoming record
  always_comb begin
    push_ent.rec.k0  = in_data.key_first;
    push_ent.rec.k1  = in_data.key_second;
    push_ent.rec.k2  = in_data.key_third;
    push_ent.keep    = keep;
    push_ent.close   = in_data.batch_end;
    push_ent.dropped = drop_r || !keep;
  end

  // advance batch count and drop flag
  always_comb begin
    count_nxt = count_r;
    drop_nxt  = drop_r;
    if (push) begin
      if (in_data.batch_end) begin
        count_nxt = '0;
        drop_nxt  = 1'b0;
      end else begin
        if (keep) count_nxt = count_r + 1'b1;
        else      drop_nxt  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      drop_r  <= 1'b0;
    end else begin
      count_r <= count_nxt;
      drop_r  <= drop_nxt;
    end
  end

endmodule

>>> hw/rtl/tkrs_queue.sv
// ----------------------------------------------------------------------------
// tkrs_queue: short FIFO between front and back
// Two-entry register queue so each side stalls on its own.
// ----------------------------------------------------------------------------
module tkrs_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  tkrs_pkg::q_ent_t push_ent,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output tkrs_pkg::q_ent_t head
);

  localparam int unsigned PtrW = $clog2(tkrs_pkg::QueueDepth);

  tkrs_pkg::q_ent_t      mem_r [tkrs_pkg::QueueDepth];
  logic [PtrW-1:0]       wp_r, rp_r;
  logic [PtrW:0]         cnt_r, cnt_nxt;

  assign full      = cnt_r == (PtrW+1)'(tkrs_pkg::QueueDepth);
  assign not_empty = cnt_r != '0;
  assign head      = mem_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    else if (!push && pop) cnt_nxt = cnt_r - 1'b1;
  end

  // store entry
  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_ent;
  end

  // advance pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

>>> hw/rtl/tkrs_back.sv
// ----------------------------------------------------------------------------
// tkrs_back: insertion sorter and emitter
// Loads kept records into the store, runs an insertion sort one shift per
// cycle through the store memory, then emits records in order.
// ----------------------------------------------------------------------------
module tkrs_back #(
  parameter int unsigned MAX_RECORDS = tkrs_pkg::MaxRecordsDefault
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  tkrs_pkg::q_ent_t   q_head,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output tkrs_pkg::out_rec_t out_data
);

  localparam int unsigned IdxW = $clog2(MAX_RECORDS);
  localparam int unsigned CntW = $clog2(MAX_RECORDS + 1);

  tkrs_pkg::bk_state_t state_r, state_nxt;

  tkrs_pkg::rec_t store_r [MAX_RECORDS];

  logic [CntW-1:0] n_r, n_nxt;       // stored records
  logic [CntW-1:0] i_r, i_nxt;       // next record to insert
  logic [CntW-1:0] j_r, j_nxt;       // hole position
  logic [CntW-1:0] e_r, e_nxt;       // emit index
  logic            ovf_r, ovf_nxt;
  logic            sub_r, sub_nxt;   // 0: fetch cur, 1: shifting
  tkrs_pkg::rec_t  cur_r, cur_nxt;

  // store port control
  logic            wr_en;
  logic [IdxW-1:0] wr_addr;
  tkrs_pkg::rec_t  wr_data;
  logic [IdxW-1:0] rd_addr;
  tkrs_pkg::rec_t  rd_data_r;

  // output register
  logic               ov_r, ov_nxt;
  tkrs_pkg::out_rec_t od_r, od_nxt;
  logic               rd_pend_r, rd_pend_nxt;
  logic               out_free;

  assign out_valid = ov_r;
  assign out_data  = od_r;
  assign out_free  = !ov_r || out_ready;

  // store memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (wr_en) store_r[wr_addr] <= wr_data;
    rd_data_r <= store_r[rd_addr];
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tkrs_pkg::ST_LOAD: begin
        if (q_valid && q_head.close) begin
          state_nxt = tkrs_pkg::ST_SORT;
        end
      end
      tkrs_pkg::ST_SORT: begin
        if (i_r >= n_r) state_nxt = tkrs_pkg::ST_EMIT;
      end
      tkrs_pkg::ST_EMIT: begin
        if (out_free && ov_r && od_r.out_last) state_nxt = tkrs_pkg::ST_LOAD;
      end
      default: state_nxt = tkrs_pkg::ST_LOAD;
    endcase
  end

  // datapath and outputs
  always_comb begin
    pop         = 1'b0;
    wr_en       = 1'b0;
    wr_addr     = '0;
    wr_data     = q_head.rec;
    rd_addr     = '0;
    n_nxt       = n_r;
    i_nxt       = i_r;
    j_nxt       = j_r;
    e_nxt       = e_r;
    ovf_nxt     = ovf_r;
    sub_nxt     = sub_r;
    cur_nxt     = cur_r;
    rd_pend_nxt = 1'b0;
    ov_nxt      = ov_r;
    od_nxt      = od_r;
    if (out_ready) ov_nxt = 1'b0;
    case (state_r)
      tkrs_pkg::ST_LOAD: begin
        if (q_valid) begin
          pop = 1'b1;
          if (q_head.keep) begin
            wr_en   = 1'b1;
            wr_addr = n_r[IdxW-1:0];
            n_nxt   = n_r + 1'b1;
          end
          if (q_head.close) begin
            ovf_nxt = q_head.dropped;
            i_nxt   = CntW'(1);
            sub_nxt = 1'b0;
            if (q_head.keep) begin
              // a kept closing entry is written like any other kept entry
            end
          end
        end
      end
      tkrs_pkg::ST_SORT: begin
        if (i_r < n_r) begin
          if (!sub_r) begin
            // fetch record i, then compare with i-1
            rd_addr = i_r[IdxW-1:0];
            sub_nxt = 1'b1;
            j_nxt   = i_r;
            rd_pend_nxt = 1'b1;
          end else if (rd_pend_r) begin
            // cur arrives; request j-1
            cur_nxt = rd_data_r;
            rd_addr = IdxW'(j_r - 1'b1);
          end else begin
            // rd_data_r holds store[j-1]
            if (j_r != '0 && tkrs_pkg::goes_before(cur_r, rd_data_r)) begin
              wr_en   = 1'b1;
              wr_addr = j_r[IdxW-1:0];
              wr_data = rd_data_r;
              j_nxt   = j_r - 1'b1;
              rd_addr = IdxW'(j_r - 2'd2);
            end else begin
              wr_en   = 1'b1;
              wr_addr = j_r[IdxW-1:0];
              wr_data = cur_r;
              i_nxt   = i_r + 1'b1;
              sub_nxt = 1'b0;
            end
          end
        end else begin
          e_nxt = '0;
        end
      end
      tkrs_pkg::ST_EMIT: begin
        // rd_addr tracks e_r so the registered read holds record e
        rd_addr = e_r[IdxW-1:0];
        if (out_free && !(ov_r && od_r.out_last)) begin
          if (!rd_pend_r) begin
            rd_pend_nxt = 1'b1;
          end else begin
            ov_nxt            = 1'b1;
            od_nxt.out_first  = rd_data_r.k0;
            od_nxt.out_second = rd_data_r.k1;
            od_nxt.out_third  = rd_data_r.k2;
            od_nxt.out_last   = (e_r + 1'b1) == n_r;
            od_nxt.overflow   = ovf_r;
            e_nxt             = e_r + 1'b1;
            rd_addr           = IdxW'(e_r + 1'b1);
            rd_pend_nxt       = 1'b1;
          end
        end else if (ov_r && od_r.out_last && out_ready) begin
          n_nxt = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    od_r  <= od_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= tkrs_pkg::ST_LOAD;
      n_r       <= '0;
      i_r       <= '0;
      j_r       <= '0;
      e_r       <= '0;
      ovf_r     <= 1'b0;
      sub_r     <= 1'b0;
      rd_pend_r <= 1'b0;
      ov_r      <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      n_r       <= n_nxt;
      i_r       <= i_nxt;
      j_r       <= j_nxt;
      e_r       <= e_nxt;
      ovf_r     <= ovf_nxt;
      sub_r     <= sub_nxt;
      rd_pend_r <= rd_pend_nxt;
      ov_r      <= ov_nxt;
    end
  end

endmodule

>>> hw/rtl/three_key_record_sorter.sv
// ----------------------------------------------------------------------------
// three_key_record_sorter: batch sorter, descending on three signed keys
// Records enter one per cycle while loading; the record flagged batch_end
// closes the batch. The stored records (at most MAX_RECORDS; later ones are
// dropped and overflow is set on the whole batch) are then insertion sorted
// in a store memory with one write and one registered read port: each record
// is fetched, then loaded as the current record, then compared and shifted
// once per position it moves, and is finally written into its place.
// Emission then gives one result per cycle while the receiver is ready,
// after a priming read, and primes the read again after each stall in
// which a result waits for out_ready. Input is accepted through a two-entry
// queue and stalls while a batch is sorted or emitted.
// ----------------------------------------------------------------------------
module three_key_record_sorter #(
  parameter int unsigned MAX_RECORDS = tkrs_pkg::MaxRecordsDefault
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  tkrs_pkg::in_rec_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output tkrs_pkg::out_rec_t out_data
);

  logic             push, q_full, pop, q_valid;
  tkrs_pkg::q_ent_t push_ent, q_head;

  tkrs_front #(.MAX_RECORDS(MAX_RECORDS)) u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_data,
    .push, .push_ent, .q_full
  );

  tkrs_queue u_queue (
    .clk, .rst_n, .push, .push_ent, .full(q_full),
    .pop, .not_empty(q_valid), .head(q_head)
  );

  tkrs_back #(.MAX_RECORDS(MAX_RECORDS)) u_back (
    .clk, .rst_n, .q_valid, .q_head, .pop,
    .out_valid, .out_ready, .out_data
  );

endmodule
